// File: sv/magic_length_prefixed_deframer_defines.svh
// assertion macros for the deframer
`ifndef MAGIC_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define MLPD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define MLPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define MLPD_ASSERT_ALWAYS(lbl, expr, msg)
`define MLPD_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// File: sv/mlpd_pkg.sv
`default_nettype none
package mlpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxLenW = 31;
  localparam int unsigned GatherW = 24;

  localparam logic [MaxLenW-1:0] MaxLenReset = 31'd1048576;

  localparam logic [ByteW-1:0] MarkFirst  = 8'h59;
  localparam logic [ByteW-1:0] MarkSecond = 8'h48;

  // phase codes
  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhAfterY = 3'd1;
  localparam logic [2:0] PhLen0   = 3'd2;
  localparam logic [2:0] PhLen1   = 3'd3;
  localparam logic [2:0] PhLen2   = 3'd4;
  localparam logic [2:0] PhLen3   = 3'd5;
  localparam logic [2:0] PhBody   = 3'd6;

  typedef struct packed {
    logic [ByteW-1:0] body_byte;
    logic             last_of_frame;
    logic             empty_frame;
  } result_t;

endpackage
`default_nettype wire

// File: sv/magic_length_prefixed_deframer.sv
// path: an accepted byte is held in the input register, then its result is registered in the output stage
// throughput: one byte per cycle while the output accepts, with a two-deep output skid
// the core adds no stall; input waits only while the skid word is held
// reset (rst, synchronous, active high) returns to the hunt, empties the
// input, output and skid stages and sets max_body_length to 1048576
`default_nettype none
`include "magic_length_prefixed_deframer_defines.svh"
module magic_length_prefixed_deframer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mlpd_pkg::MaxLenW-1:0] cfg_wr_data,   // max_body_length
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] byte_in
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] body_byte
  output logic                              m_axis_tlast,  // last_of_frame
  output logic                              m_axis_tuser   // [0] empty_frame
);
  import mlpd_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             out_room;
  logic             step;
  logic             res_valid;
  result_t          res;
  result_t          out_word;
  logic             empty_word_ok;

  // a held word moves on when the output side has room
  assign step = in_valid && out_room;

  // input register
  mlpd_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_data  (s_axis_tdata),
    .s_ready (s_axis_tready),
    .consume (step),
    .q_valid (in_valid),
    .q_data  (in_byte)
  );

  // marker hunt, length gather and body pass
  mlpd_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .byte_in     (in_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register with skid stage
  mlpd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .push    (res_valid),
    .din     (res),
    .room    (out_room),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (out_word)
  );

  assign m_axis_tdata = out_word.body_byte;
  assign m_axis_tlast = out_word.last_of_frame;
  assign m_axis_tuser = out_word.empty_frame;

  // shape of an empty-frame word
  assign empty_word_ok = m_axis_tlast && (m_axis_tdata == '0);

  // checks
  `MLPD_ASSERT_ALWAYS(a_push_has_room, !res_valid || out_room, "result pushed with no room")
  `MLPD_ASSERT_IMPLY(a_empty_is_last, m_axis_tvalid && m_axis_tuser, empty_word_ok, "bad empty word")
  `MLPD_ASSERT_IMPLY(a_stall_means_held, !s_axis_tready, in_valid && !out_room, "bad stall")

endmodule
`default_nettype wire

// File: sv/mlpd_in_reg.sv
`default_nettype none
module mlpd_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_valid,
  input  wire logic [mlpd_pkg::ByteW-1:0] s_data,
  output logic                            s_ready,
  input  wire logic                       consume,
  output logic                            q_valid,
  output logic [mlpd_pkg::ByteW-1:0]      q_data
);
  import mlpd_pkg::*;

  // room when empty or when the held word leaves this cycle
  assign s_ready = !q_valid || consume;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      q_valid <= 1'b1;
    end else if (consume) begin
      q_valid <= 1'b0;
    end
  end

  // held word
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q_data <= s_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/mlpd_fsm.sv
`default_nettype none
module mlpd_fsm (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mlpd_pkg::MaxLenW-1:0] cfg_wr_data,
  input  wire logic                         step,
  input  wire logic [mlpd_pkg::ByteW-1:0]   byte_in,
  output logic                              res_valid,
  output mlpd_pkg::result_t                 res
);
  import mlpd_pkg::*;

  logic [MaxLenW-1:0] max_len;
  logic [2:0]         phase;
  logic [2:0]         phase_next;
  logic [GatherW-1:0] gather;
  logic [GatherW-1:0] gather_next;
  logic [MaxLenW-1:0] remaining;
  logic [MaxLenW-1:0] remaining_next;
  logic [31:0]        full_len;
  logic               rem_nonzero;

  // full length once the fourth byte arrives
  assign full_len    = {byte_in, gather};
  assign rem_nonzero = (remaining != '0);

  // max length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MaxLenReset;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  // next state and result for one word
  always_comb begin
    phase_next     = phase;
    gather_next    = gather;
    remaining_next = remaining;
    res_valid      = 1'b0;
    res            = '0;
    unique case (phase) inside
      PhAfterY: begin
        gather_next = '0;
        phase_next  = (byte_in == MarkSecond) ? PhLen0 : PhHunt;
      end
      PhLen0: begin
        gather_next[7:0] = byte_in;
        phase_next       = PhLen1;
      end
      PhLen1: begin
        gather_next[15:8] = byte_in;
        phase_next        = PhLen2;
      end
      PhLen2: begin
        gather_next[23:16] = byte_in;
        phase_next         = PhLen3;
      end
      PhLen3: begin
        if (full_len[31] || (full_len[MaxLenW-1:0] > max_len)) begin
          phase_next = PhHunt;
        end else if (full_len == '0) begin
          phase_next              = PhHunt;
          remaining_next          = '0;
          res_valid               = 1'b1;
          res.last_of_frame       = 1'b1;
          res.empty_frame         = 1'b1;
        end else begin
          remaining_next = full_len[MaxLenW-1:0];
          phase_next     = PhBody;
        end
      end
      PhBody: begin
        remaining_next    = remaining - {{(MaxLenW-1){1'b0}}, rem_nonzero};
        res_valid         = 1'b1;
        res.body_byte     = byte_in;
        res.last_of_frame = (remaining_next == '0);
        if (remaining_next == '0) begin
          phase_next = PhHunt;
        end
      end
      default: begin
        phase_next = (byte_in == MarkFirst) ? PhAfterY : PhHunt;
      end
    endcase
    if (!step) begin
      res_valid = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PhHunt;
      gather    <= '0;
      remaining <= '0;
    end else if (step) begin
      phase     <= phase_next;
      gather    <= gather_next;
      remaining <= remaining_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/mlpd_out_reg.sv
`default_nettype none
module mlpd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  mlpd_pkg::result_t      din,
  output logic                   room,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output mlpd_pkg::result_t      m_data
);
  import mlpd_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    load_main;

  // room is registered: only the skid stage blocks the core
  assign room      = !skid_valid;
  assign load_main = !m_valid || m_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      if (skid_valid) begin
        m_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_main) begin
      m_data <= skid_valid ? skid : din;
    end else if (push) begin
      skid <= din;
    end
  end

endmodule
`default_nettype wire
